@@ design/sphf_pkg.sv @@
`default_nettype none
package sphf_pkg;

  localparam int NUM_TYPES = 2;
  localparam int TYPE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [TYPE_W-1:0] TYPE_A = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_B = 2'd2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIM_3D = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEWTON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_11 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_12 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_22 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIF_11 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIF_12 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIF_22 = 3'd7;

  localparam logic [31:0] CUT_RESET = 32'h0001_0000;

  // Lucy kernel scale, unsigned Q16.16
  localparam logic [20:0] KC_3D = 21'd1642785;
  localparam logic [20:0] KC_2D = 21'd1251645;

  // pipeline stage map
  localparam int DIV_STEPS = 64;
  localparam int SQ_STEPS  = 32;
  localparam int Q_STEPS   = 5;
  localparam int Q_SPAN    = DIV_STEPS + 1;
  localparam int N_MUL     = 5;
  localparam int MUL_SPAN  = 4;

  localparam int ST_CAP = 0;
  localparam int ST_MUL = 1;
  localparam int ST_SUM = 2;
  localparam int ST_CMP = 3;
  localparam int ST_MP0 = ST_CMP;
  localparam int ST_MP1 = ST_MP0 + DIV_STEPS - 1;
  localparam int ST_SQ0 = ST_CMP + 1;
  localparam int ST_SQ1 = ST_SQ0 + SQ_STEPS - 1;
  localparam int ST_W   = ST_SQ1 + 1;
  localparam int ST_T0  = ST_W + 1;
  localparam int ST_T1  = ST_T0 + DIV_STEPS - 1;
  localparam int ST_TT  = ST_T1 + 1;
  localparam int ST_Q0  = ST_TT + 1;
  localparam int ST_Q1  = ST_Q0 + Q_SPAN * Q_STEPS - 1;
  localparam int ST_SEL = ST_Q1 + 1;
  localparam int ST_X0  = ST_SEL + 1;
  localparam int ST_X1  = ST_X0 + MUL_SPAN * N_MUL - 1;
  localparam int ST_OUT = ST_X1 + 1;
  localparam int NSTAGE = ST_OUT + 1;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [TYPE_W-1:0]  type_own;
    logic [TYPE_W-1:0]  type_partner;
    logic [31:0]        mass_own;
    logic [31:0]        mass_partner;
    logic [31:0]        density_own;
    logic [31:0]        density_partner;
    logic signed [31:0] energy_own;
    logic signed [31:0] energy_partner;
    logic               partner_local;
  } in_t;

  typedef struct packed {
    logic               in_range;
    logic signed [63:0] energy_rate;
    logic               update_partner;
  } out_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] den;
    logic [63:0] quo;
    logic        sat;
  } div_t;

  typedef struct packed {
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] res;
  } sqrt_t;

  typedef struct packed {
    logic         ok;
    logic         dim;
    logic         upd;
    logic         pos;
    logic         neg;
    logic         inr;
    logic [31:0]  h;
    logic [31:0]  d;
    logic [31:0]  ax;
    logic [31:0]  ay;
    logic [31:0]  az;
    logic [32:0]  a_de;
    logic [31:0]  mi;
    logic [32:0]  mj2;
    logic [32:0]  msum;
    logic [31:0]  ri;
    logic [31:0]  rj;
    logic [32:0]  rsum;
    logic [63:0]  sx;
    logic [63:0]  sy;
    logic [63:0]  sz;
    logic [63:0]  hsq;
    logic [63:0]  rsq;
    logic [63:0]  rprod;
    logic [64:0]  mprod;
    sqrt_t        sq;
    div_t         kdiv;
    div_t         mdiv;
    div_t         pdiv;
    logic [63:0]  x;
    logic [63:0]  qs;
    logic [63:0]  pll;
    logic [63:0]  plh;
    logic [63:0]  phl;
    logic [63:0]  phh;
    logic [64:0]  pmid;
    logic [127:0] prod;
    out_t         res;
  } ctx_t;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // floor(hi:lo / den), saturating when the quotient needs more than 64 bits
  function automatic div_t div_init(logic [63:0] hi, logic [63:0] lo, logic [63:0] den);
    div_t s;
    s.rem = hi;
    s.lo  = lo;
    s.den = den;
    s.quo = '0;
    s.sat = (den == '0) || (hi >= den);
    return s;
  endfunction

  function automatic div_t div_step(div_t s);
    div_t        n;
    logic [64:0] r2;
    logic [64:0] dif;
    n   = s;
    r2  = {s.rem, s.lo[63]};
    dif = r2 - {1'b0, s.den};
    n.lo = {s.lo[62:0], 1'b0};
    if (r2 >= {1'b0, s.den}) begin
      n.rem = dif[63:0];
      n.quo = {s.quo[62:0], 1'b1};
    end else begin
      n.rem = r2[63:0];
      n.quo = {s.quo[62:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [63:0] div_res(div_t s);
    return s.sat ? '1 : s.quo;
  endfunction

  // one root bit per call, two radicand bits consumed
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       n;
    logic [35:0] s2;
    logic [35:0] trial;
    logic [35:0] dif;
    s2    = {s.rem, s.v[63:62]};
    trial = {2'b00, s.res, 2'b01};
    dif   = s2 - trial;
    n.v   = {s.v[61:0], 2'b00};
    if (s2 >= trial) begin
      n.rem = dif[33:0];
      n.res = {s.res[30:0], 1'b1};
    end else begin
      n.rem = s2[33:0];
      n.res = {s.res[30:0], 1'b0};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ design/sphf_if.sv @@
`default_nettype none
interface sphf_in_if;
  logic            valid;
  logic            ready;
  sphf_pkg::in_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sphf_out_if;
  logic            valid;
  logic            ready;
  sphf_pkg::out_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/sph_pair_heat_flux_top.sv @@
`default_nettype none
// SPH heat-conduction pair unit with the Lucy kernel. Each beat on pair_i is one neighbor
// pair; each beat on flux_o is its result: in_range, the saturating Q32.32 energy rate for
// the own particle, and whether the partner takes the negated rate. The unit is a fixed
// pipeline of 449 register stages and takes one pair every cycle while flux_o is not held.
// The depth is set by the restoring dividers (t = w/h and the five q/h steps, 64 quotient
// bits each, one bit per stage), the 32-stage square root and five 64x64 multiplies split
// into 32x32 partial products. The whole pipe holds while a result waits on flux_o, so
// nothing is lost or repeated. Configuration registers (dimension, Newton flag, cutoffs,
// diffusion per type pair) are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while the pipe is empty, which the block itself does not enforce.
module sph_pair_heat_flux_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  sphf_in_if.sink                            pair_i,
  sphf_out_if.source                         flux_o,
  input  wire                                cfg_we_i,
  input  wire [sphf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [sphf_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int NS = sphf_pkg::NSTAGE;
  localparam int TW = sphf_pkg::TYPE_W;

  logic        dim_q, newton_q;
  logic [31:0] cut11_q, cut12_q, cut22_q;
  logic [31:0] dif11_q, dif12_q, dif22_q;

  logic [NS-1:0]  valid_q;
  sphf_pkg::ctx_t ctx_q [NS];
  sphf_pkg::ctx_t ctx_d [NS];
  logic           adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= 1'b1;
      newton_q <= 1'b0;
      cut11_q  <= sphf_pkg::CUT_RESET;
      cut12_q  <= sphf_pkg::CUT_RESET;
      cut22_q  <= sphf_pkg::CUT_RESET;
      dif11_q  <= '0;
      dif12_q  <= '0;
      dif22_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sphf_pkg::REG_DIM_3D: dim_q    <= cfg_data_i[0];
        sphf_pkg::REG_NEWTON: newton_q <= cfg_data_i[0];
        sphf_pkg::REG_CUT_11: cut11_q  <= cfg_data_i;
        sphf_pkg::REG_CUT_12: cut12_q  <= cfg_data_i;
        sphf_pkg::REG_CUT_22: cut22_q  <= cfg_data_i;
        sphf_pkg::REG_DIF_11: dif11_q  <= cfg_data_i;
        sphf_pkg::REG_DIF_12: dif12_q  <= cfg_data_i;
        sphf_pkg::REG_DIF_22: dif22_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the whole pipe only while a finished result waits downstream.
  assign adv          = !valid_q[sphf_pkg::ST_OUT] || flux_o.ready;
  assign pair_i.ready = adv;
  assign flux_o.valid = valid_q[sphf_pkg::ST_OUT];
  assign flux_o.data  = ctx_q[sphf_pkg::ST_OUT].res;

  // Capture stage: type check, type-pair lookup, magnitudes and sums.
  always_comb begin
    logic [TW-1:0] ta, tb;
    logic [32:0]   de;
    ta = pair_i.data.type_own;
    tb = pair_i.data.type_partner;
    de = {pair_i.data.energy_own[31], pair_i.data.energy_own}
       - {pair_i.data.energy_partner[31], pair_i.data.energy_partner};
    ctx_d[0]     = '0;
    ctx_d[0].ok  = (ta != '0) && (ta <= TW'(sphf_pkg::NUM_TYPES))
                && (tb != '0) && (tb <= TW'(sphf_pkg::NUM_TYPES));
    if (ta == sphf_pkg::TYPE_A && tb == sphf_pkg::TYPE_A) begin
      ctx_d[0].h = cut11_q;
      ctx_d[0].d = dif11_q;
    end else if (ta == sphf_pkg::TYPE_B && tb == sphf_pkg::TYPE_B) begin
      ctx_d[0].h = cut22_q;
      ctx_d[0].d = dif22_q;
    end else begin
      ctx_d[0].h = cut12_q;
      ctx_d[0].d = dif12_q;
    end
    ctx_d[0].dim  = dim_q;
    ctx_d[0].upd  = newton_q | pair_i.data.partner_local;
    ctx_d[0].ax   = sphf_pkg::abs32(pair_i.data.dx);
    ctx_d[0].ay   = sphf_pkg::abs32(pair_i.data.dy);
    ctx_d[0].az   = sphf_pkg::abs32(pair_i.data.dz);
    ctx_d[0].neg  = de[32];
    ctx_d[0].pos  = !de[32] && (de != '0);
    ctx_d[0].a_de = de[32] ? (~de + 33'd1) : de;
    ctx_d[0].mi   = pair_i.data.mass_own;
    ctx_d[0].mj2  = {pair_i.data.mass_partner, 1'b0};
    ctx_d[0].msum = {1'b0, pair_i.data.mass_own} + {1'b0, pair_i.data.mass_partner};
    ctx_d[0].ri   = pair_i.data.density_own;
    ctx_d[0].rj   = pair_i.data.density_partner;
    ctx_d[0].rsum = {1'b0, pair_i.data.density_own} + {1'b0, pair_i.data.density_partner};
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    localparam int QJ = (k - sphf_pkg::ST_Q0) / sphf_pkg::Q_SPAN;
    localparam int QR = (k - sphf_pkg::ST_Q0) % sphf_pkg::Q_SPAN;
    localparam int MI = (k - sphf_pkg::ST_X0) / sphf_pkg::MUL_SPAN;
    localparam int MP = (k - sphf_pkg::ST_X0) % sphf_pkg::MUL_SPAN;

    always_comb begin
      logic [63:0] y;
      logic [63:0] src;
      logic [65:0] tt;
      logic [32:0] t;
      ctx_d[k] = ctx_q[k-1];
      y   = '0;
      src = '0;
      tt  = '0;
      t   = '0;

      // squares, h*h and the mass and density products
      if (k == sphf_pkg::ST_MUL) begin
        ctx_d[k].sx    = 64'(ctx_q[k-1].ax) * 64'(ctx_q[k-1].ax);
        ctx_d[k].sy    = 64'(ctx_q[k-1].ay) * 64'(ctx_q[k-1].ay);
        ctx_d[k].sz    = 64'(ctx_q[k-1].az) * 64'(ctx_q[k-1].az);
        ctx_d[k].hsq   = 64'(ctx_q[k-1].h) * 64'(ctx_q[k-1].h);
        ctx_d[k].rprod = 64'(ctx_q[k-1].ri) * 64'(ctx_q[k-1].rj);
        ctx_d[k].mprod = 65'(ctx_q[k-1].mi) * 65'(ctx_q[k-1].mj2);
      end

      // distance sum; set up the mass and density dividers
      if (k == sphf_pkg::ST_SUM) begin
        ctx_d[k].rsq  = ctx_q[k-1].sx + ctx_q[k-1].sy + ctx_q[k-1].sz;
        ctx_d[k].mdiv = sphf_pkg::div_init({63'b0, ctx_q[k-1].mprod[64]},
                                           ctx_q[k-1].mprod[63:0],
                                           {31'b0, ctx_q[k-1].msum});
        ctx_d[k].pdiv = sphf_pkg::div_init({63'b0, ctx_q[k-1].rsum[32]},
                                           {ctx_q[k-1].rsum[31:0], 32'b0},
                                           ctx_q[k-1].rprod);
      end

      if (k == sphf_pkg::ST_CMP) begin
        ctx_d[k].inr    = ctx_q[k-1].ok && (ctx_q[k-1].rsq < ctx_q[k-1].hsq);
        ctx_d[k].sq.v   = ctx_q[k-1].rsq;
        ctx_d[k].sq.rem = '0;
        ctx_d[k].sq.res = '0;
      end

      if (k >= sphf_pkg::ST_MP0 && k <= sphf_pkg::ST_MP1) begin
        ctx_d[k].mdiv = sphf_pkg::div_step(ctx_q[k-1].mdiv);
        ctx_d[k].pdiv = sphf_pkg::div_step(ctx_q[k-1].pdiv);
      end

      if (k >= sphf_pkg::ST_SQ0 && k <= sphf_pkg::ST_SQ1) begin
        ctx_d[k].sq = sphf_pkg::sqrt_step(ctx_q[k-1].sq);
      end

      // w = h - r, then t = w * 2^32 / h
      if (k == sphf_pkg::ST_W) begin
        ctx_d[k].kdiv = sphf_pkg::div_init('0,
                                           {ctx_q[k-1].h - ctx_q[k-1].sq.res, 32'b0},
                                           {32'b0, ctx_q[k-1].h});
      end

      if (k >= sphf_pkg::ST_T0 && k <= sphf_pkg::ST_T1) begin
        ctx_d[k].kdiv = sphf_pkg::div_step(ctx_q[k-1].kdiv);
      end

      // q = t*t / 2^32; t never exceeds 2^32 for a pair in range
      if (k == sphf_pkg::ST_TT) begin
        src        = sphf_pkg::div_res(ctx_q[k-1].kdiv);
        t          = src[32:0];
        tt         = 66'(t) * 66'(t);
        ctx_d[k].x = 64'(tt[65:32]);
      end

      // q = q * 2^16 / h, repeated; keep the fourth result for 2D
      if (k >= sphf_pkg::ST_Q0 && k <= sphf_pkg::ST_Q1) begin
        if (QR == 0) begin
          src = (QJ == 0) ? ctx_q[k-1].x : sphf_pkg::div_res(ctx_q[k-1].kdiv);
          if (QJ == sphf_pkg::Q_STEPS - 1) begin
            ctx_d[k].qs = src;
          end
          ctx_d[k].kdiv = sphf_pkg::div_init({48'b0, src[63:48]}, {src[47:0], 16'b0},
                                             {32'b0, ctx_q[k-1].h});
        end else begin
          ctx_d[k].kdiv = sphf_pkg::div_step(ctx_q[k-1].kdiv);
        end
      end

      if (k == sphf_pkg::ST_SEL) begin
        ctx_d[k].x = ctx_q[k-1].dim ? sphf_pkg::div_res(ctx_q[k-1].kdiv) : ctx_q[k-1].qs;
      end

      // x = x * operand / 2^16, saturating: kernel scale, D, M, P, |ei - ej|
      if (k >= sphf_pkg::ST_X0 && k <= sphf_pkg::ST_X1) begin
        if (MP == 0) begin
          unique case (MI)
            0:       y = ctx_q[k-1].dim ? 64'(sphf_pkg::KC_3D) : 64'(sphf_pkg::KC_2D);
            1:       y = 64'(ctx_q[k-1].d);
            2:       y = sphf_pkg::div_res(ctx_q[k-1].mdiv);
            3:       y = sphf_pkg::div_res(ctx_q[k-1].pdiv);
            default: y = 64'(ctx_q[k-1].a_de);
          endcase
          ctx_d[k].pll = 64'(ctx_q[k-1].x[31:0])  * 64'(y[31:0]);
          ctx_d[k].plh = 64'(ctx_q[k-1].x[31:0])  * 64'(y[63:32]);
          ctx_d[k].phl = 64'(ctx_q[k-1].x[63:32]) * 64'(y[31:0]);
          ctx_d[k].phh = 64'(ctx_q[k-1].x[63:32]) * 64'(y[63:32]);
        end else if (MP == 1) begin
          ctx_d[k].pmid = {1'b0, ctx_q[k-1].plh} + {1'b0, ctx_q[k-1].phl};
        end else if (MP == 2) begin
          ctx_d[k].prod = {ctx_q[k-1].phh, ctx_q[k-1].pll}
                        + {31'b0, ctx_q[k-1].pmid, 32'b0};
        end else begin
          ctx_d[k].x = (|ctx_q[k-1].prod[127:80]) ? '1 : ctx_q[k-1].prod[79:16];
        end
      end

      // sign and clamp into Q32.32; zero the result of pairs out of range
      if (k == sphf_pkg::ST_OUT) begin
        ctx_d[k].res = '0;
        if (ctx_q[k-1].inr) begin
          ctx_d[k].res.in_range       = 1'b1;
          ctx_d[k].res.update_partner = ctx_q[k-1].upd;
          if (ctx_q[k-1].pos) begin
            ctx_d[k].res.energy_rate = (ctx_q[k-1].x[63] && (|ctx_q[k-1].x[62:0]))
                                     ? {1'b1, 63'b0} : (~ctx_q[k-1].x + 64'd1);
          end else if (ctx_q[k-1].neg) begin
            ctx_d[k].res.energy_rate = ctx_q[k-1].x[63] ? {1'b0, {63{1'b1}}}
                                                         : ctx_q[k-1].x;
          end
        end
      end
    end
  end

  // Advance valid bits and payload together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NS-2:0], pair_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q <= ctx_d;
    end
  end

`ifndef SYNTHESIS
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[sphf_pkg::ST_OUT] && !flux_o.ready |-> !pair_i.ready)
    else $error("input taken while the pipe is held");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_i.valid && pair_i.ready |=> valid_q[0])
    else $error("accepted pair missing from the first stage");

  a_partner_needs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flux_o.valid && (flux_o.data.update_partner || flux_o.data.energy_rate != '0)
      |-> flux_o.data.in_range)
    else $error("result for a pair out of range");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_sph_pair_heat_flux_top.sv @@
`default_nettype none
module tb_sph_pair_heat_flux_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sphf_pkg::*;

  localparam int PIPE_DEPTH  = 449;
  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 1200;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  sphf_in_if  pair_if();
  sphf_out_if flux_if();

  sph_pair_heat_flux_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_i     (pair_if),
    .flux_o     (flux_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copy of the register file, updated with every write.
  logic        sh_dim_3d;
  logic        sh_newton;
  logic [31:0] sh_cutoff [3];
  logic [31:0] sh_diffusion [3];

  out_t flux_expected [$];
  int   fail_count;
  int   quiet_cycles;
  bit   no_idle;
  bit   hold_request;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // floor(a*b/c) from the full 128-bit product, saturated to all ones.
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] c);
    logic [127:0] prod;
    if (c == '0) return '1;
    prod = {64'd0, a} * {64'd0, b};
    if (prod[127:64] >= c) return '1;
    return 64'(prod / {64'd0, c});
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != '0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] square_abs(logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return {32'd0, m} * {32'd0, m};
  endfunction

  // Heat-flux rate of one pair under the shadow configuration.
  function automatic out_t predict_flux(in_t p);
    out_t        r;
    int          slot;
    logic [63:0] h, d, rsq, w, q, x, kc, mfac, pfac, diff;
    longint      de;
    r = '0;
    if (p.type_own < TYPE_A || p.type_own > TYPE_B ||
        p.type_partner < TYPE_A || p.type_partner > TYPE_B) return r;
    if (p.type_own == TYPE_A && p.type_partner == TYPE_A) slot = 0;
    else if (p.type_own == TYPE_B && p.type_partner == TYPE_B) slot = 2;
    else slot = 1;
    h   = {32'd0, sh_cutoff[slot]};
    d   = {32'd0, sh_diffusion[slot]};
    rsq = square_abs(p.dx) + square_abs(p.dy) + square_abs(p.dz);
    if (!(rsq < h * h)) return r;
    w = h - floor_root(rsq);
    q = scaled_product(w, 64'd1 << 32, h);
    q = scaled_product(q, q, 64'd1 << 32);
    for (int n = 0; n < (sh_dim_3d ? 5 : 4); n++) q = scaled_product(q, 64'd65536, h);
    kc   = sh_dim_3d ? 64'(KC_3D) : 64'(KC_2D);
    x    = scaled_product(q, kc, 64'd65536);
    mfac = scaled_product({32'd0, p.mass_own}, {31'd0, p.mass_partner, 1'b0},
                          {32'd0, p.mass_own} + {32'd0, p.mass_partner});
    pfac = scaled_product({32'd0, p.density_own} + {32'd0, p.density_partner},
                          64'd1 << 32, {32'd0, p.density_own} * {32'd0, p.density_partner});
    de   = longint'(p.energy_own) - longint'(p.energy_partner);
    diff = (de < 0) ? 64'(-de) : 64'(de);
    x = scaled_product(x, d, 64'd65536);
    x = scaled_product(x, mfac, 64'd65536);
    x = scaled_product(x, pfac, 64'd65536);
    x = scaled_product(x, diff, 64'd65536);
    if (de > 0) begin
      r.energy_rate = -((x > (64'd1 << 63)) ? (64'd1 << 63) : x);
    end else if (de < 0) begin
      r.energy_rate = (x > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : x;
    end
    r.in_range       = 1'b1;
    r.update_partner = sh_newton | p.partner_local;
    return r;
  endfunction

  // Compare each accepted result beat with the oldest expectation; also run the
  // watchdog on cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if ((pair_if.valid && pair_if.ready) || (flux_if.valid && flux_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_sph_pair_heat_flux_top: FAIL");
        $finish;
      end else if (flux_if.valid && flux_if.ready) begin
        if (flux_expected.size() == 0) begin
          $error("unexpected result beat %p", flux_if.data);
          fail_count++;
        end else begin
          want = flux_expected.pop_front();
          if (flux_if.data.in_range !== want.in_range) begin
            $error("in_range: expected %0d, got %0d", want.in_range, flux_if.data.in_range);
            fail_count++;
          end
          if (flux_if.data.energy_rate !== want.energy_rate) begin
            $error("energy_rate: expected %0d, got %0d", want.energy_rate,
                   flux_if.data.energy_rate);
            fail_count++;
          end
          if (flux_if.data.update_partner !== want.update_partner) begin
            $error("update_partner: expected %0d, got %0d", want.update_partner,
                   flux_if.data.update_partner);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side: random short stalls, or one long hold-off on request.
  initial begin
    flux_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        flux_if.ready <= 1'b0;
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        flux_if.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        flux_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        flux_if.ready <= 1'b1;
      end else begin
        flux_if.ready <= 1'b1;
      end
    end
  end

  // Offer one pair beat, hold it until accepted, then queue its expected flux.
  task automatic send_pair(in_t p);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      pair_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.data  <= p;
    do @(posedge clk_i); while (!pair_if.ready);
    flux_expected.push_back(predict_flux(p));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected beat has come out.
  task automatic drain_pipe();
    pair_if.valid <= 1'b0;
    while (flux_expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_DIM_3D: sh_dim_3d       = value[0];
      REG_NEWTON: sh_newton       = value[0];
      REG_CUT_11: sh_cutoff[0]    = value;
      REG_CUT_12: sh_cutoff[1]    = value;
      REG_CUT_22: sh_cutoff[2]    = value;
      REG_DIF_11: sh_diffusion[0] = value;
      REG_DIF_12: sh_diffusion[1] = value;
      REG_DIF_22: sh_diffusion[2] = value;
      default: ;
    endcase
  endtask

  task automatic write_all(logic dim, logic newton, logic [31:0] cut, logic [31:0] dif);
    write_reg(REG_DIM_3D, {31'd0, dim});
    write_reg(REG_NEWTON, {31'd0, newton});
    write_reg(REG_CUT_11, cut);
    write_reg(REG_CUT_12, cut);
    write_reg(REG_CUT_22, cut);
    write_reg(REG_DIF_11, dif);
    write_reg(REG_DIF_12, dif);
    write_reg(REG_DIF_22, dif);
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] floor_val);
    case ($urandom_range(0, 5))
      0: return floor_val;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom_range(32'h400, 32'h10_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] offset_within(logic [31:0] span);
    logic [31:0] m;
    m = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Well-formed pair inside the cutoff of its type pair, or pure noise.
  function automatic in_t random_pair(bit well_formed);
    in_t         p;
    logic [31:0] h;
    p = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
    if (well_formed) begin
      p.type_own     = 2'($urandom_range(1, 2));
      p.type_partner = 2'($urandom_range(1, 2));
      h = (p.type_own != p.type_partner) ? sh_cutoff[1] :
          (p.type_own == TYPE_A) ? sh_cutoff[0] : sh_cutoff[2];
      p.dx = offset_within(h >> 1);
      p.dy = offset_within(h >> 1);
      p.dz = offset_within(h >> 1);
      if ($urandom_range(0, 3) == 0) p.energy_partner = p.energy_own;
      if ($urandom_range(0, 2) == 0) begin
        p.mass_own        = $urandom_range(1, 32'h4_0000);
        p.mass_partner    = $urandom_range(1, 32'h4_0000);
        p.density_own     = $urandom_range(1, 32'h4_0000);
        p.density_partner = $urandom_range(1, 32'h4_0000);
      end
    end
    return p;
  endfunction

  function automatic in_t make_pair(logic signed [31:0] dx, logic [1:0] ta, logic [1:0] tb,
                                    logic [31:0] mass, logic [31:0] rho,
                                    logic signed [31:0] ei, logic signed [31:0] ej,
                                    logic loc);
    in_t p;
    p.dx = dx;
    p.dy = '0;
    p.dz = '0;
    p.type_own = ta;
    p.type_partner = tb;
    p.mass_own = mass;
    p.mass_partner = mass;
    p.density_own = rho;
    p.density_partner = rho;
    p.energy_own = ei;
    p.energy_partner = ej;
    p.partner_local = loc;
    return p;
  endfunction

  // Extremes of the fields and the named special cases, 3D then 2D with Newton.
  task automatic test_directed();
    in_t p;
    write_all(1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000);
    write_reg(REG_CUT_12, 32'h0002_0000);
    send_pair(make_pair(32'sd0, TYPE_A, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd65536, 32'sd0, 1'b1));
    send_pair(make_pair(32'sd0, TYPE_A, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd0, 32'sd65536, 1'b0));
    send_pair(make_pair(32'sd100, TYPE_B, TYPE_B, 32'h1_0000, 32'h1_0000, 32'sd5, 32'sd5, 1'b0));
    send_pair(make_pair(32'sd300, TYPE_A, TYPE_B, 32'h1_0000, 32'h1_0000,
                        32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
    send_pair(make_pair(32'sd300, TYPE_B, TYPE_A, 32'h1_0000, 32'h1_0000,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
    // exactly on the cutoff and far away (out of range), and just inside it
    send_pair(make_pair(32'sd65536, TYPE_A, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd9, 32'sd0, 1'b1));
    send_pair(make_pair(-32'sd65535, TYPE_A, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd9, 32'sd0, 1'b1));
    send_pair(make_pair(32'sh8000_0000, TYPE_A, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd9, 32'sd0, 1'b1));
    // types outside the valid set on either side
    send_pair(make_pair(32'sd0, 2'd0, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd9, 32'sd0, 1'b1));
    send_pair(make_pair(32'sd0, TYPE_B, 2'd3, 32'h1_0000, 32'h1_0000, 32'sd9, 32'sd0, 1'b1));
    // zero and extreme masses and densities drive the saturation chain
    send_pair(make_pair(32'sd10, TYPE_A, TYPE_A, 32'd0, 32'h1_0000, 32'sd9, 32'sd0, 1'b1));
    send_pair(make_pair(32'sd10, TYPE_A, TYPE_A, 32'h1_0000, 32'd0, 32'sd9, 32'sd0, 1'b1));
    send_pair(make_pair(32'sd10, TYPE_A, TYPE_A, 32'hFFFF_FFFF, 32'd1,
                        32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
    send_pair(make_pair(32'sd10, TYPE_A, TYPE_A, 32'd1, 32'hFFFF_FFFF,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
    drain_pipe();
    write_all(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    p = make_pair(32'sh7FFF_FFFF, TYPE_A, TYPE_B, 32'hFFFF_FFFF, 32'd1,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    p.dy = 32'sh8000_0001;
    send_pair(p);
    send_pair(make_pair(32'sd1, TYPE_B, TYPE_B, 32'h1_0000, 32'h1_0000, 32'sd1, 32'sd2, 1'b0));
    send_pair(make_pair(32'sd0, TYPE_A, TYPE_A, 32'hFFFF_FFFF, 32'd1,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
    drain_pipe();
    // tiny and zero cutoffs
    write_reg(REG_CUT_11, 32'd1);
    write_reg(REG_CUT_22, 32'd0);
    write_reg(REG_DIF_11, 32'd0);
    send_pair(make_pair(32'sd0, TYPE_A, TYPE_A, 32'h1_0000, 32'h1_0000, 32'sd0, 32'sd7, 1'b0));
    send_pair(make_pair(32'sd0, TYPE_B, TYPE_B, 32'h1_0000, 32'h1_0000, 32'sd0, 32'sd7, 1'b1));
    drain_pipe();
  endtask

  // One phase: random settings, then mostly in-range pairs with some noise.
  task automatic test_random_phase(int count);
    write_reg(REG_DIM_3D, $urandom_range(0, 1));
    write_reg(REG_NEWTON, $urandom_range(0, 1));
    write_reg(REG_CUT_11, pick_value(32'd1));
    write_reg(REG_CUT_12, pick_value(32'd1));
    write_reg(REG_CUT_22, pick_value(32'd1));
    write_reg(REG_DIF_11, pick_value(32'd0));
    write_reg(REG_DIF_12, pick_value(32'd0));
    write_reg(REG_DIF_22, pick_value(32'd0));
    repeat (count) send_pair(random_pair($urandom_range(0, 9) < 8));
    drain_pipe();
  endtask

  // Hold the result side for a long stretch so the pipe fills and stalls pair_i.
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (600) send_pair(random_pair(1'b1));
    drain_pipe();
  endtask

  initial begin
    fail_count    = 0;
    quiet_cycles  = 0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    pair_if.valid = 1'b0;
    pair_if.data  = '0;
    sh_dim_3d     = 1'b1;
    sh_newton     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sh_cutoff[i]    = CUT_RESET;
      sh_diffusion[i] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    repeat (3) test_random_phase(250);
    test_backpressure();
    // final stretch runs with both sides always ready
    no_idle = 1'b1;
    test_random_phase(200);

    repeat (PIPE_DEPTH + 50) @(posedge clk_i);
    if (fail_count == 0 && flux_expected.size() == 0) begin
      $display("tb_sph_pair_heat_flux_top: PASS");
    end else begin
      $display("tb_sph_pair_heat_flux_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
